[rtl/core/fpeb_pkg.sv]
// fpeb_pkg: shared types, command and register codes, smoothing weight table
// for the four-pass exponential blur. No dependencies.
`timescale 1ns / 1ps

package fpeb_pkg;

    // Command codes carried by one input word
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_BLUR  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_RECT_LEFT   = 3'd0;
    localparam logic [2:0] CFG_RECT_TOP    = 3'd1;
    localparam logic [2:0] CFG_RECT_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_RECT_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_RADIUS      = 3'd4;
    localparam logic [2:0] CFG_ALPHA_ONLY  = 3'd5;

    // Configuration field widths and reset values
    localparam int COORD_W  = 8;
    localparam int RADIUS_W = 6;
    localparam int ALPHA_W  = 5;
    localparam int ACC_W    = 12;
    localparam int CHANNELS = 4;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd5;
    localparam logic [COORD_W-1:0]  RIGHT_RESET  = 8'd255;
    localparam logic [COORD_W-1:0]  BOTTOM_RESET = 8'd255;

    // Smoothing weight per radius 1..17 (weight is in sixteenths)
    localparam logic [ALPHA_W-1:0] ALPHA_TABLE [17] = '{
        5'd14, 5'd10, 5'd8, 5'd6, 5'd5, 5'd5, 5'd4, 5'd3, 5'd3,
        5'd3,  5'd3,  5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2
    };

    localparam logic [RADIUS_W-1:0] RADIUS_TABLE_MAX = 6'd17;

    // Weight from radius: full weight at zero, minimum weight past the table
    function automatic logic [ALPHA_W-1:0] alpha_of(input logic [RADIUS_W-1:0] r);
        logic [ALPHA_W-1:0] a;
        if (r == '0) begin
            a = 5'd16;
        end else if (r > RADIUS_TABLE_MAX) begin
            a = 5'd1;
        end else begin
            a = ALPHA_TABLE[5'(r - 6'd1)];
        end
        return a;
    endfunction

    // Sequencer control toward the store and the filter lanes
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic               seed;
        logic               filt;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } seq_ctl_t;

endpackage

[rtl/core/fpeb_store.sv]
// fpeb_store: single-port synchronous pixel store with a registered read.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module fpeb_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // Write or registered read, one access per cycle
    always_ff @(posedge clk)
    begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fpeb_filter.sv]
// fpeb_filter: four byte lanes of the recursive smoothing step with their
// accumulators. Depends on fpeb_pkg.
`timescale 1ns / 1ps

module fpeb_filter
    import fpeb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  seq_ctl_t           ctl,
    input  logic [ALPHA_W-1:0] alpha,
    input  logic               alpha_only,
    input  logic [31:0]        rdata,
    output logic [31:0]        wdata
);

    genvar ch;
    generate
        for (ch = 0; ch < CHANNELS; ch++) begin : g_lane
            logic [ACC_W-1:0]  acc_reg;
            logic [ACC_W-1:0]  acc_next;
            logic [ACC_W-1:0]  p16;
            logic signed [12:0] diff;
            logic signed [5:0]  alpha_s;
            logic signed [18:0] prod;
            logic signed [18:0] biased;
            logic signed [18:0] step;
            logic [ACC_W-1:0]  nv;
            logic              active;

            // Lane 3 is alpha and always filters
            assign active = (ch == CHANNELS - 1) || !alpha_only;

            // acc + ((p<<4) - acc) * alpha / 16, division toward zero
            assign p16     = {rdata[8*ch+7:8*ch], 4'b0000};
            assign diff    = $signed({1'b0, p16}) - $signed({1'b0, acc_reg});
            assign alpha_s = $signed({1'b0, alpha});
            assign prod    = diff * alpha_s;
            assign biased  = prod + (prod[18] ? 19'sd15 : 19'sd0);
            assign step    = biased >>> 4;
            assign nv      = acc_reg + step[ACC_W-1:0];

            always_comb
            begin
                acc_next = acc_reg;
                if (active && ctl.seed) begin
                    acc_next = p16;
                end else if (active && ctl.filt) begin
                    acc_next = nv;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_next;
                end
            end

            // Write back the new byte, leave idle lanes as read
            assign wdata[8*ch+7:8*ch] = (active && ctl.filt) ? nv[ACC_W-1:4]
                                                             : rdata[8*ch+7:8*ch];
        end
    endgenerate

endmodule

[rtl/core/fpeb_seq.sv]
// fpeb_seq: walks the rectangle in four passes (down, right, up, left), one
// read per pixel and a write-back for each pixel but a line's first. Depends on fpeb_pkg.
`timescale 1ns / 1ps

module fpeb_seq
    import fpeb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] c1,
    input  logic [COORD_W-1:0] c2,
    input  logic [COORD_W-1:0] r1,
    input  logic [COORD_W-1:0] r2,
    output seq_ctl_t           ctl,
    output logic               busy,
    output logic               done
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_PROC = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        PASS_DOWN  = 2'd0,
        PASS_RIGHT = 2'd1,
        PASS_UP    = 2'd2,
        PASS_LEFT  = 2'd3
    } pass_t;

    state_t             state_reg, state_next;
    pass_t              pass_reg, pass_next;
    logic [COORD_W-1:0] line_reg, line_next;
    logic [COORD_W-1:0] pos_reg, pos_next;
    logic               first_reg, first_next;

    logic               col_pass;
    logic [COORD_W-1:0] line_hi;
    logic [COORD_W-1:0] pos_last;

    // First position of a line in a given pass
    function automatic logic [COORD_W-1:0] pos_first_of(
        input pass_t p, input logic [COORD_W-1:0] a1, input logic [COORD_W-1:0] a2,
        input logic [COORD_W-1:0] b1, input logic [COORD_W-1:0] b2);
        logic [COORD_W-1:0] v;
        case (p)
            PASS_DOWN:  v = b1;
            PASS_RIGHT: v = a1;
            PASS_UP:    v = b2;
            PASS_LEFT:  v = a2;
            default:    v = b1;
        endcase
        return v;
    endfunction

    // First line of a given pass
    function automatic logic [COORD_W-1:0] line_first_of(
        input pass_t p, input logic [COORD_W-1:0] a1, input logic [COORD_W-1:0] b1);
        logic [COORD_W-1:0] v;
        if (p == PASS_DOWN || p == PASS_UP) begin
            v = a1;
        end else begin
            v = b1;
        end
        return v;
    endfunction

    // Pass geometry: columns run over rows, rows run over columns
    always_comb
    begin
        col_pass = (pass_reg == PASS_DOWN) || (pass_reg == PASS_UP);
        line_hi  = col_pass ? c2 : r2;
        case (pass_reg)
            PASS_DOWN:  pos_last = r2;
            PASS_RIGHT: pos_last = c2;
            PASS_UP:    pos_last = r1;
            PASS_LEFT:  pos_last = c1;
            default:    pos_last = r2;
        endcase
    end

    // Walk control
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        line_next  = line_reg;
        pos_next   = pos_reg;
        first_next = first_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    state_next = S_READ;
                    pass_next  = PASS_DOWN;
                    line_next  = c1;
                    pos_next   = r1;
                    first_next = 1'b1;
                end
            end
            S_READ:
            begin
                state_next = S_PROC;
            end
            S_PROC:
            begin
                state_next = S_READ;
                first_next = 1'b0;
                if (pos_reg == pos_last) begin
                    first_next = 1'b1;
                    if (line_reg == line_hi) begin
                        if (pass_reg == PASS_LEFT) begin
                            state_next = S_IDLE;
                            done       = 1'b1;
                        end else begin
                            pass_next = pass_t'(pass_reg + 2'd1);
                            line_next = line_first_of(pass_next, c1, r1);
                            pos_next  = pos_first_of(pass_next, c1, c2, r1, r2);
                        end
                    end else begin
                        line_next = line_reg + 8'd1;
                        pos_next  = pos_first_of(pass_reg, c1, c2, r1, r2);
                    end
                end else if (pass_reg == PASS_DOWN || pass_reg == PASS_RIGHT) begin
                    pos_next = pos_reg + 8'd1;
                end else begin
                    pos_next = pos_reg - 8'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            pass_reg  <= PASS_DOWN;
            line_reg  <= '0;
            pos_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

    // Store and lane control; the first pixel of a line only seeds
    always_comb
    begin
        ctl.rd   = (state_reg == S_READ);
        ctl.wr   = (state_reg == S_PROC) && !first_reg;
        ctl.seed = (state_reg == S_PROC) && first_reg;
        ctl.filt = (state_reg == S_PROC) && !first_reg;
        ctl.x    = col_pass ? line_reg : pos_reg;
        ctl.y    = col_pass ? pos_reg : line_reg;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/core/four_pass_exponential_blur.sv]
// Four-pass exponential blur: pixel store with write, blur and read commands.
// Every command returns one result word; a blur walks a W x H rectangle in
// four passes, reading each pixel and writing back all but the first of a line.
// Throughput: one command at a time; the single store port sets the blur time.
// Reset returns control and configuration to their reset values; store contents stay undefined.
// Depends on fpeb_pkg, fpeb_store, fpeb_filter, fpeb_seq.
`timescale 1ns / 1ps

module four_pass_exponential_blur
    import fpeb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_ready,
    input  logic [1:0]   cmd,
    input  logic [7:0]   pixel_x,
    input  logic [7:0]   pixel_y,
    input  logic [31:0]  pixel_in,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [31:0]  pixel_out,
    output logic         done_res,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] WIDTH_A = AW'(MAX_WIDTH);
    localparam logic [12:0]   XLIM    = 13'(MAX_WIDTH - 1);
    localparam logic [12:0]   YLIM    = 13'(MAX_HEIGHT - 1);
    localparam logic [12:0]   XCNT    = 13'(MAX_WIDTH);
    localparam logic [12:0]   YCNT    = 13'(MAX_HEIGHT);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_READ = 3'b010,
        T_BLUR = 3'b100
    } tstate_t;

    tstate_t               state_reg, state_next;

    logic [COORD_W-1:0]    left_reg, top_reg, right_reg, bottom_reg;
    logic [RADIUS_W-1:0]   radius_reg;
    logic                  alpha_only_reg;

    logic                  in_range_reg;
    logic                  res_valid_reg;
    logic [31:0]           pixel_out_reg;
    logic                  hold_valid_reg;
    logic [31:0]           hold_pix_reg;

    logic                  accept;
    logic                  in_range;
    logic                  empty_rect;
    logic [COORD_W-1:0]    c1, c2, r1, r2;
    logic                  fin;
    logic [31:0]           fin_pix;
    logic                  take;
    logic                  seq_start;

    seq_ctl_t              ctl;
    logic                  seq_busy;
    logic                  seq_done;

    logic [COORD_W-1:0]    ax, ay;
    logic [AW-1:0]         mem_addr;
    logic                  mem_en, mem_we;
    logic [31:0]           mem_wdata;
    logic [31:0]           mem_rdata;
    logic [31:0]           filt_wdata;
    logic [ALPHA_W-1:0]    alpha;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_reg       <= '0;
            top_reg        <= '0;
            right_reg      <= RIGHT_RESET;
            bottom_reg     <= BOTTOM_RESET;
            radius_reg     <= RADIUS_RESET;
            alpha_only_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RECT_LEFT:   left_reg       <= cfg_data;
                CFG_RECT_TOP:    top_reg        <= cfg_data;
                CFG_RECT_RIGHT:  right_reg      <= cfg_data;
                CFG_RECT_BOTTOM: bottom_reg     <= cfg_data;
                CFG_RADIUS:      radius_reg     <= cfg_data[RADIUS_W-1:0];
                CFG_ALPHA_ONLY:  alpha_only_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Rectangle clamped to the store
    assign c1 = (13'(left_reg) > XLIM)   ? XLIM[COORD_W-1:0] : left_reg;
    assign c2 = (13'(right_reg) > XLIM)  ? XLIM[COORD_W-1:0] : right_reg;
    assign r1 = (13'(top_reg) > YLIM)    ? YLIM[COORD_W-1:0] : top_reg;
    assign r2 = (13'(bottom_reg) > YLIM) ? YLIM[COORD_W-1:0] : bottom_reg;
    assign empty_rect = (c1 > c2) || (r1 > r2);

    assign alpha    = alpha_of(radius_reg);
    assign in_range = (13'(pixel_x) < XCNT) && (13'(pixel_y) < YCNT);

    // Command handshake: only one command in flight, result slot must be free
    assign cmd_ready = (state_reg == T_IDLE) && !hold_valid_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign seq_start = accept && (cmd == CMD_BLUR) && !empty_rect;

    // Command control and completion
    always_comb
    begin
        state_next = state_reg;
        fin        = 1'b0;
        fin_pix    = '0;
        case (state_reg)
            T_IDLE:
            begin
                if (accept) begin
                    case (cmd)
                        CMD_READ: state_next = T_READ;
                        CMD_BLUR:
                        begin
                            if (empty_rect) begin
                                fin = 1'b1;
                            end else begin
                                state_next = T_BLUR;
                            end
                        end
                        default:  fin = 1'b1;
                    endcase
                end
            end
            T_READ:
            begin
                fin        = 1'b1;
                fin_pix    = in_range_reg ? mem_rdata : 32'd0;
                state_next = T_IDLE;
            end
            T_BLUR:
            begin
                if (seq_done) begin
                    fin        = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= T_IDLE;
            in_range_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                in_range_reg <= in_range;
            end
        end
    end

    // Output register with one skid word behind it
    assign take = res_valid_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (fin) begin
            if (!res_valid_reg || take) begin
                res_valid_reg <= 1'b1;
            end else begin
                hold_valid_reg <= 1'b1;
            end
        end else if (take) begin
            if (hold_valid_reg) begin
                hold_valid_reg <= 1'b0;
            end else begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin) begin
            if (!res_valid_reg || take) begin
                pixel_out_reg <= fin_pix;
            end else begin
                hold_pix_reg <= fin_pix;
            end
        end else if (take && hold_valid_reg) begin
            pixel_out_reg <= hold_pix_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign done_res  = 1'b1;

    // Store port: sequencer during a blur, command port otherwise
    assign ax       = seq_busy ? ctl.x : pixel_x;
    assign ay       = seq_busy ? ctl.y : pixel_y;
    assign mem_addr = AW'(ay) * WIDTH_A + AW'(ax);

    always_comb
    begin
        if (seq_busy) begin
            mem_en    = ctl.rd || ctl.wr;
            mem_we    = ctl.wr;
            mem_wdata = filt_wdata;
        end else begin
            mem_en    = accept && in_range && ((cmd == CMD_WRITE) || (cmd == CMD_READ));
            mem_we    = accept && in_range && (cmd == CMD_WRITE);
            mem_wdata = pixel_in;
        end
    end

    fpeb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fpeb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .c1    (c1),
        .c2    (c2),
        .r1    (r1),
        .r2    (r2),
        .ctl   (ctl),
        .busy  (seq_busy),
        .done  (seq_done)
    );

    fpeb_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .alpha      (alpha),
        .alpha_only (alpha_only_reg),
        .rdata      (mem_rdata),
        .wdata      (filt_wdata)
    );

    // Checks
    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> res_valid_reg)
        else $error("skid word held with empty output register");

    a_ready_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !seq_busy)
        else $error("command accepted during a blur");

    a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.rd && ctl.wr))
        else $error("sequencer reads and writes the store in one cycle");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_READ)) |=> (state_reg == T_READ))
        else $error("read command did not wait for store data");

    a_done_in_blur: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> (state_reg == T_BLUR))
        else $error("blur finished outside a blur command");

endmodule
